### sv/byte_stack_with_rotate_unit_assert.svh
// assertion macros for the byte stack with rotate unit
`ifndef BYTE_STACK_WITH_ROTATE_UNIT_ASSERT_SVH
`define BYTE_STACK_WITH_ROTATE_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define BSTK_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define BSTK_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/bstk_pkg.sv
// shared types and constants for the byte stack with rotate unit
`timescale 1ns / 1ps

package bstk_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int DATA_W        = 8;
    localparam int OP_W          = 3;
    localparam int CNT_W         = 7;
    localparam int CAP_W         = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // operation codes; codes 6 and 7 do nothing
    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 3'd0,
        OP_POP  = 3'd1,
        OP_PEEK = 3'd2,
        OP_DUP  = 3'd3,
        OP_UROT = 3'd4,
        OP_DROT = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADROT = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RDWAIT,
        S_ROT_HOLD,
        S_ROT_MOVE,
        S_ROT_LAST,
        S_RESP
    } state_t;

    // result handed from the sequencer to the output stage
    typedef struct packed {
        status_t             status;
        logic [DATA_W-1:0]   data;
        logic                data_valid;
    } resp_t;

endpackage

### sv/bstk_mem.sv
// stack storage: one write port, one registered read port
`timescale 1ns / 1ps

module bstk_mem import bstk_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, old data on a same-address collision
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/bstk_ctrl.sv
// sequencer: decodes a request and moves entries one per cycle through the memory port
`timescale 1ns / 1ps

module bstk_ctrl import bstk_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH),
    parameter int OCC_W = $clog2(DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_operation,
    input  logic [DATA_W-1:0] s_push_value,
    input  logic [CNT_W-1:0]  s_rotate_count,
    input  logic [CAP_W-1:0]  capacity,
    input  logic              out_free,
    output resp_t             resp,
    output logic              resp_load,
    output logic              mem_wr_en,
    output logic [AW-1:0]     mem_wr_addr,
    output logic [DATA_W-1:0] mem_wr_data,
    output logic [AW-1:0]     mem_rd_addr,
    input  logic [DATA_W-1:0] mem_rd_data
);

    localparam int W1    = (OCC_W > CNT_W) ? OCC_W : CNT_W;
    localparam int CMP_W = (W1 > CAP_W) ? W1 : CAP_W;

    state_t            state_reg, state_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic [AW-1:0]     end_reg, end_next;
    logic [DATA_W-1:0] held_reg, held_next;
    logic              dir_up_reg, dir_up_next;
    resp_t             res_reg, res_next;

    logic [CMP_W-1:0]  occ_ext, cap_ext, cnt_ext;
    logic              is_full, is_empty, rot_bad;
    logic [AW-1:0]     top_idx, low_idx, occ_idx;
    logic [AW-1:0]     ptr_step, ptr_step2;

    // occupancy checks against the capacity limit, saturated at DEPTH
    always_comb begin
        occ_ext  = CMP_W'(occ_reg);
        cap_ext  = CMP_W'(capacity);
        cnt_ext  = CMP_W'(cnt_reg);
        is_full  = (occ_ext >= cap_ext) || (occ_reg == OCC_W'(DEPTH));
        is_empty = (occ_reg == '0);
        rot_bad  = (cnt_reg == '0) || (cnt_ext > occ_ext);
        top_idx  = AW'(occ_ext - CMP_W'(1));
        low_idx  = AW'(occ_ext - cnt_ext);
        occ_idx  = AW'(occ_reg);
    end

    // pointer stepper shared by both rotate directions
    always_comb begin
        ptr_step  = dir_up_reg ? (ptr_reg - AW'(1)) : (ptr_reg + AW'(1));
        ptr_step2 = dir_up_reg ? (ptr_reg - AW'(2)) : (ptr_reg + AW'(2));
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        val_reg    <= val_next;
        cnt_reg    <= cnt_next;
        ptr_reg    <= ptr_next;
        end_reg    <= end_next;
        held_reg   <= held_next;
        dir_up_reg <= dir_up_next;
        res_reg    <= res_next;
    end

    // next state and outputs
    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        val_next    = val_reg;
        cnt_next    = cnt_reg;
        occ_next    = occ_reg;
        ptr_next    = ptr_reg;
        end_next    = end_reg;
        held_next   = held_reg;
        dir_up_next = dir_up_reg;
        res_next    = res_reg;
        s_ready     = 1'b0;
        resp_load   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = ptr_reg;
        mem_wr_data = mem_rd_data;
        mem_rd_addr = ptr_reg;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next    = s_operation;
                    val_next   = s_push_value;
                    cnt_next   = s_rotate_count;
                    state_next = S_DECODE;
                end
            end

            S_DECODE: begin
                res_next.status     = ST_OK;
                res_next.data       = '0;
                res_next.data_valid = 1'b0;
                state_next          = S_RESP;
                unique case (op_t'(op_reg))
                    OP_PUSH: begin
                        if (is_full) begin
                            res_next.status = ST_FULL;
                        end else begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = occ_idx;
                            mem_wr_data = val_reg;
                            occ_next    = occ_reg + OCC_W'(1);
                        end
                    end
                    OP_POP, OP_PEEK: begin
                        if (is_empty) begin
                            res_next.status = ST_EMPTY;
                        end else begin
                            mem_rd_addr = top_idx;
                            state_next  = S_RDWAIT;
                        end
                    end
                    OP_DUP: begin
                        if (is_full) begin
                            res_next.status = ST_FULL;
                        end else if (is_empty) begin
                            res_next.status = ST_EMPTY;
                        end else begin
                            mem_rd_addr = top_idx;
                            state_next  = S_RDWAIT;
                        end
                    end
                    OP_UROT, OP_DROT: begin
                        if (rot_bad) begin
                            res_next.status = ST_BADROT;
                        end else if (cnt_reg != CNT_W'(1)) begin
                            // fetch the entry that wraps around, then start moving
                            dir_up_next = (op_t'(op_reg) == OP_UROT);
                            mem_rd_addr = (op_t'(op_reg) == OP_UROT) ? top_idx : low_idx;
                            ptr_next    = (op_t'(op_reg) == OP_UROT) ? top_idx : low_idx;
                            end_next    = (op_t'(op_reg) == OP_UROT) ? low_idx : top_idx;
                            state_next  = S_ROT_HOLD;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            S_RDWAIT: begin
                if (op_t'(op_reg) == OP_DUP) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = occ_idx;
                    mem_wr_data = mem_rd_data;
                    occ_next    = occ_reg + OCC_W'(1);
                end else begin
                    res_next.data       = mem_rd_data;
                    res_next.data_valid = 1'b1;
                    if (op_t'(op_reg) == OP_POP) begin
                        occ_next = occ_reg - OCC_W'(1);
                    end
                end
                state_next = S_RESP;
            end

            S_ROT_HOLD: begin
                held_next   = mem_rd_data;
                mem_rd_addr = ptr_step;
                state_next  = S_ROT_MOVE;
            end

            // one entry shifts per cycle; the next source is read meanwhile
            S_ROT_MOVE: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = ptr_reg;
                mem_wr_data = mem_rd_data;
                if (ptr_step == end_reg) begin
                    ptr_next   = end_reg;
                    state_next = S_ROT_LAST;
                end else begin
                    ptr_next    = ptr_step;
                    mem_rd_addr = ptr_step2;
                end
            end

            S_ROT_LAST: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = ptr_reg;
                mem_wr_data = held_reg;
                state_next  = S_RESP;
            end

            S_RESP: begin
                if (out_free) begin
                    resp_load  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign resp = res_reg;

endmodule

### sv/byte_stack_with_rotate_unit.sv
// Byte-wide LIFO stack with push, pop, peek, dup and up/down rotate. One request is
// handled at a time. Pop, peek and dup wait for a memory read. A rotate over n entries
// (n of 2 or more) reads the entry that wraps around, moves the remaining entries through
// the single memory read port and write port, one entry per cycle, and then writes the
// held entry back. A rotate of one entry moves nothing. A finished result sits in an
// output register, so a new request is taken while the previous result still waits.
// The capacity register is written through cfg_wr_en / cfg_wr_data and resets to 64;
// values above DEPTH act as DEPTH. Stack entries are not cleared by reset.
`timescale 1ns / 1ps
`include "byte_stack_with_rotate_unit_assert.svh"

module byte_stack_with_rotate_unit import bstk_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CAP_W-1:0]  cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_operation,
    input  logic [DATA_W-1:0] s_push_value,
    input  logic [CNT_W-1:0]  s_rotate_count,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic [DATA_W-1:0] m_data_out,
    output logic              m_data_valid
);

    localparam int AW = $clog2(DEPTH);

    logic [CAP_W-1:0]  capacity_reg;
    logic              m_valid_reg;
    logic [1:0]        m_status_reg;
    logic [DATA_W-1:0] m_data_out_reg;
    logic              m_data_valid_reg;

    resp_t             resp;
    logic              resp_load;
    logic              out_free;
    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic [DATA_W-1:0] mem_wr_data;
    logic [AW-1:0]     mem_rd_addr;
    logic [DATA_W-1:0] mem_rd_data;

    // capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            capacity_reg <= cfg_wr_data;
        end
    end

    // output stage
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (resp_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (resp_load) begin
            m_status_reg     <= resp.status;
            m_data_out_reg   <= resp.data;
            m_data_valid_reg <= resp.data_valid;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_data_out   = m_data_out_reg;
    assign m_data_valid = m_data_valid_reg;

    // sequencer
    bstk_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_push_value   (s_push_value),
        .s_rotate_count (s_rotate_count),
        .capacity       (capacity_reg),
        .out_free       (out_free),
        .resp           (resp),
        .resp_load      (resp_load),
        .mem_wr_en      (mem_wr_en),
        .mem_wr_addr    (mem_wr_addr),
        .mem_wr_data    (mem_wr_data),
        .mem_rd_addr    (mem_rd_addr),
        .mem_rd_data    (mem_rd_data)
    );

    // stack storage
    bstk_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // checks
    `BSTK_ASSERT_NXT(a_accept_busy, aclk, aresetn, s_valid && s_ready, !s_ready,
                     "request accepted while busy")
    `BSTK_ASSERT_IMP(a_no_overwrite, aclk, aresetn, resp_load, out_free,
                     "result overwrote a waiting result")
    `BSTK_ASSERT_IMP(a_data_ok, aclk, aresetn, m_valid && m_data_valid, m_status == ST_OK,
                     "returned byte with error status")

endmodule
